// ===== src/upe_pkg.sv =====
// Shared types, character constants and helper functions for the URL percent and
// entity decoder. No dependencies; every other file but upe_checker imports it.
package upe_pkg;

	// Character codes the decoder recognizes or produces
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_PCT   = 8'h25;
	localparam logic [7:0] CH_AMP   = 8'h26;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_L     = 8'h4C;
	localparam logic [7:0] CH_G     = 8'h47;
	localparam logic [7:0] CH_T     = 8'h54;
	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_GT    = 8'h3E;

	// Most results one input character can cause, and the queue depth
	localparam int unsigned MAX_RES = 4;
	localparam int unsigned Q_DEPTH = 4;

	// One queue entry: every result byte caused by one input character
	typedef struct packed {
		logic [MAX_RES-1:0][7:0] bytes;
		logic [2:0]              cnt;
		logic                    last;
	} entry_t;

	// Fold lower-case ASCII letters onto upper case
	function automatic logic [7:0] upper_ascii(input logic [7:0] c);
		if (c >= 8'h61 && c <= 8'h7A) begin
			return c - 8'd32;
		end
		return c;
	endfunction

	// Hex digit value; anything that is not a hex digit counts as zero
	function automatic logic [3:0] hex_value(input logic [7:0] c);
		logic [7:0] d;
		d = 8'h00;
		if (c >= 8'h30 && c <= 8'h39) begin
			d = c - 8'h30;
		end else if (c >= 8'h41 && c <= 8'h46) begin
			d = c - 8'h37;
		end else if (c >= 8'h61 && c <= 8'h66) begin
			d = c - 8'h57;
		end
		return d[3:0];
	endfunction

	// Append one byte to an entry; bytes beyond the capacity are dropped
	function automatic entry_t add_byte(input entry_t e, input logic [7:0] b);
		entry_t r;
		r = e;
		if (e.cnt < 3'(MAX_RES)) begin
			r.bytes[e.cnt[1:0]] = b;
			r.cnt = e.cnt + 3'd1;
		end
		return r;
	endfunction

endpackage

// ===== src/url_percent_entity_decoder_top.sv =====
// Channel  Dir  tdata          tuser        tlast
// s_axis   in   in_char[7:0]   -            in_last
// m_axis   out  out_byte[7:0]  data_valid   out_last
//
// One input character is accepted per cycle while the queue is not full; each
// yields zero to four results, and results leave at one per cycle through the
// output register while m_tready is high. The queue of four entries lets input
// keep flowing while the output side stalls or drains a long entry.
// Reset (arst_n low) clears the parser, queue pointers and output valid flag.
// Top level: instantiates upe_front, upe_queue and upe_back; depends on upe_pkg.
module url_percent_entity_decoder_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] in_char
	input  logic       s_tlast,
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] out_byte
	output logic       m_tuser,   // [0] data_valid
	output logic       m_tlast
);
	import upe_pkg::*;

	logic   push, pop, full, empty;
	entry_t push_entry, head;

	upe_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_char    (s_tdata),
		.in_last    (s_tlast),
		.q_full     (full),
		.in_ready   (s_tready),
		.push       (push),
		.push_entry (push_entry)
	);

	upe_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.full       (full),
		.empty      (empty),
		.head       (head)
	);

	upe_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.empty      (empty),
		.head       (head),
		.pop        (pop),
		.out_ready  (m_tready),
		.out_valid  (m_tvalid),
		.out_byte   (m_tdata),
		.data_valid (m_tuser),
		.out_last   (m_tlast)
	);

endmodule

// ===== src/upe_front.sv =====
// Front end: accepts characters, runs the percent and entity parser and builds
// an entry for each character with results or a string end. Depends on upe_pkg.
module upe_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic [7:0]    in_char,
	input  logic          in_last,
	input  logic          q_full,
	output logic          in_ready,
	output logic          push,
	output upe_pkg::entry_t push_entry
);
	import upe_pkg::*;

	localparam logic [2:0] MODE_NORMAL = 3'd0;
	localparam logic [2:0] MODE_PCT1   = 3'd1;
	localparam logic [2:0] MODE_PCT2   = 3'd2;
	localparam logic [2:0] MODE_AMP1   = 3'd3;
	localparam logic [2:0] MODE_AMP2   = 3'd4;
	localparam logic [2:0] MODE_AMP3   = 3'd5;

	logic [2:0] mode_q, mode_n;
	logic [3:0] nib_q, nib_n;
	logic [7:0] h1_q, h1_n;
	logic [7:0] h2_q, h2_n;
	logic       stop_q, stop_n;
	entry_t     ent;
	logic       accept;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	// Next parser state and the result bytes of the current character
	always_comb begin
		logic       fresh;
		logic [7:0] v;
		fresh  = 1'b0;
		v      = 8'h00;
		mode_n = mode_q;
		nib_n  = nib_q;
		h1_n   = h1_q;
		h2_n   = h2_q;
		stop_n = stop_q;
		ent    = '0;

		if (!stop_q) begin
			case (mode_q)
				MODE_PCT1: begin
					if (in_char == CH_PCT) begin
						ent    = add_byte(ent, CH_PCT);
						mode_n = MODE_NORMAL;
					end else if (in_char == CH_NUL) begin
						stop_n = 1'b1;
						mode_n = MODE_NORMAL;
					end else begin
						nib_n  = hex_value(in_char);
						mode_n = MODE_PCT2;
					end
				end
				MODE_PCT2: begin
					mode_n = MODE_NORMAL;
					v      = {nib_q, hex_value(in_char)};
					if (in_char == CH_NUL || v == CH_NUL) begin
						stop_n = 1'b1;
					end else begin
						ent = add_byte(ent, v);
					end
				end
				MODE_AMP1: begin
					if (upper_ascii(in_char) == CH_L || upper_ascii(in_char) == CH_G) begin
						h1_n   = in_char;
						mode_n = MODE_AMP2;
					end else begin
						ent   = add_byte(ent, CH_AMP);
						fresh = 1'b1;
					end
				end
				MODE_AMP2: begin
					if (upper_ascii(in_char) == CH_T) begin
						h2_n   = in_char;
						mode_n = MODE_AMP3;
					end else begin
						ent   = add_byte(ent, CH_AMP);
						ent   = add_byte(ent, h1_q);
						fresh = 1'b1;
					end
				end
				MODE_AMP3: begin
					if (in_char == CH_SEMI) begin
						ent    = add_byte(ent, (upper_ascii(h1_q) == CH_L) ? CH_LT : CH_GT);
						mode_n = MODE_NORMAL;
					end else begin
						ent   = add_byte(ent, CH_AMP);
						ent   = add_byte(ent, h1_q);
						ent   = add_byte(ent, h2_q);
						fresh = 1'b1;
					end
				end
				default: begin
					fresh = 1'b1;
				end
			endcase
		end

		// Handle the character as if no escape or entity were open
		if (fresh) begin
			mode_n = MODE_NORMAL;
			if (in_char == CH_NUL) begin
				stop_n = 1'b1;
			end else if (in_char == CH_PLUS) begin
				ent = add_byte(ent, CH_SPACE);
			end else if (in_char == CH_PCT) begin
				mode_n = MODE_PCT1;
			end else if (in_char == CH_AMP) begin
				mode_n = MODE_AMP1;
			end else begin
				ent = add_byte(ent, in_char);
			end
		end

		// End of string: flush an open entity and start afresh
		if (in_last) begin
			if (!stop_n) begin
				case (mode_n)
					MODE_AMP1: begin
						ent = add_byte(ent, CH_AMP);
					end
					MODE_AMP2: begin
						ent = add_byte(ent, CH_AMP);
						ent = add_byte(ent, h1_n);
					end
					MODE_AMP3: begin
						ent = add_byte(ent, CH_AMP);
						ent = add_byte(ent, h1_n);
						ent = add_byte(ent, h2_n);
					end
					default: begin
						ent = ent;
					end
				endcase
			end
			ent.last = 1'b1;
			mode_n   = MODE_NORMAL;
			nib_n    = 4'h0;
			h1_n     = 8'h00;
			h2_n     = 8'h00;
			stop_n   = 1'b0;
		end
	end

	// A character that yields nothing and does not end the string needs no entry
	assign push       = accept && (ent.cnt != 3'd0 || in_last);
	assign push_entry = ent;

	// Parser state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_NORMAL;
			nib_q  <= 4'h0;
			h1_q   <= 8'h00;
			h2_q   <= 8'h00;
			stop_q <= 1'b0;
		end else if (accept) begin
			mode_q <= mode_n;
			nib_q  <= nib_n;
			h1_q   <= h1_n;
			h2_q   <= h2_n;
			stop_q <= stop_n;
		end
	end

endmodule

// ===== src/upe_queue.sv =====
// Short queue of result entries between the front end and the back end.
// Depends on upe_pkg for the entry type and depth.
module upe_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  upe_pkg::entry_t push_entry,
	input  logic            pop,
	output logic            full,
	output logic            empty,
	output upe_pkg::entry_t head
);
	import upe_pkg::*;

	localparam int unsigned PW = $clog2(Q_DEPTH);

	entry_t          mem_q [Q_DEPTH];
	logic [PW-1:0]   wr_q, rd_q;
	logic [PW:0]     cnt_q;
	logic            do_push, do_pop;

	assign full    = (cnt_q == (PW+1)'(Q_DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = mem_q[rd_q];

	// Entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_entry;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= wr_q + PW'(1);
			end
			if (do_pop) begin
				rd_q <= rd_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + (PW+1)'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - (PW+1)'(1);
			end
		end
	end

endmodule

// ===== src/upe_back.sv =====
// Back end: walks the bytes of the head queue entry into an output register, one
// result per cycle while not stalled. Depends on upe_pkg for the entry type.
module upe_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            empty,
	input  upe_pkg::entry_t head,
	output logic            pop,
	input  logic            out_ready,
	output logic            out_valid,
	output logic [7:0]      out_byte,
	output logic            data_valid,
	output logic            out_last
);
	import upe_pkg::*;

	logic [1:0] idx_q;
	logic       load;
	logic       final_byte;

	// The output register takes a new result whenever it is empty or being taken
	assign load       = !out_valid || out_ready;
	assign final_byte = (head.cnt == 3'd0) || ({1'b0, idx_q} == head.cnt - 3'd1);
	assign pop        = load && !empty && final_byte;

	// Byte index within the head entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= 2'd0;
		end else if (load && !empty) begin
			idx_q <= final_byte ? 2'd0 : idx_q + 2'd1;
		end
	end

	// Output register valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load) begin
			out_valid <= !empty;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (load && !empty) begin
			out_byte   <= head.bytes[idx_q];
			data_valid <= (head.cnt != 3'd0);
			out_last   <= head.last && final_byte;
		end
	end

endmodule

// ===== src/upe_checker.sv =====
// Port-level checks for the decoder output stream, bound to the top level.
// Depends only on the ports of url_percent_entity_decoder_top.
module upe_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic       m_tuser,
	input logic       m_tlast
);

	// A stalled result holds until it is taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("stalled result changed");

	// A result without data only closes a string
	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tlast)
		else $error("result without data is not marked last");

	// A result without data carries a zero byte
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata == 8'h00)
		else $error("result without data has a nonzero byte");

	// A zero byte ends the output, so it is never delivered as data
	a_no_nul: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata != 8'h00)
		else $error("zero byte delivered as data");

endmodule

bind url_percent_entity_decoder_top upe_checker u_upe_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);
